/* sv/sbsm_pkg.sv */
package sbsm_pkg;

  // top bank of the PRG space, fixed into the high window in fixed-high mode
  localparam logic [3:0] LastPrgBank = 4'd15;

  // shift count at which the next serial bit completes a register load
  localparam logic [2:0] ShiftLast = 3'd4;

  // target register picked by address bits 14:13 on a completed load
  typedef enum logic [1:0] {
    TGT_CTRL = 2'd0,
    TGT_CHR0 = 2'd1,
    TGT_CHR1 = 2'd2,
    TGT_PRG  = 2'd3
  } tgt_sel_e;

  // mapping state reported with every transaction
  typedef struct packed {
    logic [3:0] low_window_bank;
    logic [4:0] high_window_bank;
    logic [1:0] mirror_mode;
    logic       chr_mode_bit;
    logic [4:0] chr_low_bank;
    logic [4:0] chr_high_bank;
    logic       ram_disable_bit;
  } result_t;

  // one cpu write held in the input register
  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  data_byte;
  } wr_t;

endpackage

/* sv/serial_bank_switch_mapper.sv */
// serial bank-switch cartridge mapper
// input channel: in_valid_i / in_stall_o carry one cpu write transaction
//   (address_i, data_byte_i); data bit 7 resets the serial loader, otherwise
//   bit 0 is shifted in lsb first and every fifth bit loads the register
//   picked by address bits 14:13 (writes below 0x8000 load nothing)
// output channel: out_valid_o / out_stall_i carry one transaction per input
//   transaction with the mapping as it stands after that write
// path: a transaction accepted into the input stage is registered there and
//   moves on to the output register once that register is free or draining,
//   where its result is then presented to the receiver
// throughput: one transaction per cycle while out_stall_i is low; the update
//   is a 5-bit shift, a register select and a small window mux between the
//   two register stages
// stall: when the receiver stalls, the result stays in the output register,
//   the pending write waits in the input register and in_stall_o rises only
//   once both stages are full
// reset: both channels go empty, the loader is cleared, both prg mode bits
//   are set, windows read low bank 0 and high bank 1
module serial_bank_switch_mapper
  import sbsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  low_window_bank_o,
  output logic [4:0]  high_window_bank_o,
  output logic [1:0]  mirror_mode_o,
  output logic        chr_mode_bit_o,
  output logic [4:0]  chr_low_bank_o,
  output logic [4:0]  chr_high_bank_o,
  output logic        ram_disable_bit_o
);

  logic    s1_valid;
  wr_t     s1_wr;
  logic    advance;
  result_t core_res;

  logic    out_valid_q, out_valid_d;
  result_t out_res_q;

  // the held write moves on when the output register is free or draining
  assign advance = s1_valid & (~out_valid_q | ~out_stall_i);

  sbsm_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .address_i   (address_i),
    .data_byte_i (data_byte_i),
    .advance_i   (advance),
    .valid_o     (s1_valid),
    .wr_o        (s1_wr)
  );

  // mapper state commits exactly when its result enters the output register
  sbsm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .wr_i     (s1_wr),
    .result_o (core_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only with a new transaction
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign low_window_bank_o  = out_res_q.low_window_bank;
  assign high_window_bank_o = out_res_q.high_window_bank;
  assign mirror_mode_o      = out_res_q.mirror_mode;
  assign chr_mode_bit_o     = out_res_q.chr_mode_bit;
  assign chr_low_bank_o     = out_res_q.chr_low_bank;
  assign chr_high_bank_o    = out_res_q.chr_high_bank;
  assign ram_disable_bit_o  = out_res_q.ram_disable_bit;

endmodule

/* sv/sbsm_in_stage.sv */
module sbsm_in_stage
  import sbsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_byte_i,
  input  logic        advance_i,
  output logic        valid_o,
  output wr_t         wr_o
);

  logic valid_q, valid_d;
  wr_t  wr_q;
  logic accept;

  // stall only while holding a write that cannot move on
  assign in_stall_o = valid_q & ~advance_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wr_q <= '{address: address_i, data_byte: data_byte_i};
    end
  end

  assign valid_o = valid_q;
  assign wr_o    = wr_q;

endmodule

/* sv/sbsm_core.sv */
module sbsm_core
  import sbsm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  wr_t     wr_i,
  output result_t result_o
);

  logic [4:0] shift_bits_q, shift_bits_d;
  logic [2:0] shift_count_q, shift_count_d;
  logic       switch_mode_q, switch_mode_d;
  logic       fixed_sel_q, fixed_sel_d;
  logic       chr_mode_q, chr_mode_d;
  logic [1:0] mirror_q, mirror_d;
  logic [3:0] prg_bank_q, prg_bank_d;
  logic [4:0] chr_zero_q, chr_zero_d;
  logic [4:0] chr_one_q, chr_one_d;
  logic       ram_dis_q, ram_dis_d;
  logic [3:0] low_win_q, low_win_d;
  logic [4:0] high_win_q, high_win_d;

  logic [4:0] shifted;
  logic       recompute;
  tgt_sel_e   tgt;

  assign shifted = shift_bits_q | ({4'b0, wr_i.data_byte[0]} << shift_count_q);
  assign tgt     = tgt_sel_e'(wr_i.address[14:13]);

  always_comb begin
    shift_bits_d  = shift_bits_q;
    shift_count_d = shift_count_q;
    switch_mode_d = switch_mode_q;
    fixed_sel_d   = fixed_sel_q;
    chr_mode_d    = chr_mode_q;
    mirror_d      = mirror_q;
    prg_bank_d    = prg_bank_q;
    chr_zero_d    = chr_zero_q;
    chr_one_d     = chr_one_q;
    ram_dis_d     = ram_dis_q;
    recompute     = 1'b0;

    if (wr_i.data_byte[7]) begin
      // reset write: windows are left alone
      shift_bits_d  = '0;
      shift_count_d = '0;
      switch_mode_d = 1'b1;
      fixed_sel_d   = 1'b1;
    end else if (shift_count_q == ShiftLast) begin
      shift_bits_d  = '0;
      shift_count_d = '0;
      if (wr_i.address[15]) begin
        case (tgt)
          TGT_CTRL: begin
            chr_mode_d    = shifted[4];
            switch_mode_d = shifted[3];
            fixed_sel_d   = shifted[2];
            mirror_d      = shifted[1:0];
            recompute     = 1'b1;
          end
          TGT_CHR0: chr_zero_d = shifted;
          TGT_CHR1: chr_one_d  = shifted;
          TGT_PRG: begin
            ram_dis_d  = shifted[4];
            prg_bank_d = shifted[3:0];
            recompute  = 1'b1;
          end
          default: ;
        endcase
      end
    end else begin
      shift_bits_d  = shifted;
      shift_count_d = shift_count_q + 3'd1;
    end
  end

  // window mux from the updated mode and bank
  always_comb begin
    low_win_d  = low_win_q;
    high_win_d = high_win_q;
    if (recompute) begin
      if (!switch_mode_d) begin
        low_win_d  = prg_bank_d;
        high_win_d = {1'b0, prg_bank_d} + 5'd1;
      end else if (!fixed_sel_d) begin
        low_win_d  = '0;
        high_win_d = {1'b0, prg_bank_d};
      end else begin
        low_win_d  = prg_bank_d;
        high_win_d = {1'b0, LastPrgBank};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_bits_q  <= '0;
      shift_count_q <= '0;
      switch_mode_q <= 1'b1;
      fixed_sel_q   <= 1'b1;
      chr_mode_q    <= 1'b0;
      mirror_q      <= '0;
      prg_bank_q    <= '0;
      chr_zero_q    <= '0;
      chr_one_q     <= '0;
      ram_dis_q     <= 1'b0;
      low_win_q     <= '0;
      high_win_q    <= 5'd1;
    end else if (step_i) begin
      shift_bits_q  <= shift_bits_d;
      shift_count_q <= shift_count_d;
      switch_mode_q <= switch_mode_d;
      fixed_sel_q   <= fixed_sel_d;
      chr_mode_q    <= chr_mode_d;
      mirror_q      <= mirror_d;
      prg_bank_q    <= prg_bank_d;
      chr_zero_q    <= chr_zero_d;
      chr_one_q     <= chr_one_d;
      ram_dis_q     <= ram_dis_d;
      low_win_q     <= low_win_d;
      high_win_q    <= high_win_d;
    end
  end

  assign result_o = '{
    low_window_bank:  low_win_d,
    high_window_bank: high_win_d,
    mirror_mode:      mirror_d,
    chr_mode_bit:     chr_mode_d,
    chr_low_bank:     chr_zero_d,
    chr_high_bank:    chr_one_d,
    ram_disable_bit:  ram_dis_d
  };

endmodule
